FILE: rtl/core/mlfs_pkg.sv
// Shared constants and types for the multi-lane binary64 sum reduction block.
// No dependencies; the other files of the block, except mlfs_ram, refer to it by scoped names.
package mlfs_pkg;

  localparam int MAX_LANES  = 64;
  localparam int LANE_AW    = 6;   // address bits of the lane memory
  localparam int LANE_CW    = 7;   // lane count, holds MAX_LANES itself
  localparam int DATA_W     = 64;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_LANE_COUNT    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 8'd1;

  localparam logic [DATA_W-1:0] FP_POS_ZERO = 64'h0000_0000_0000_0000;
  localparam logic [DATA_W-1:0] FP_QNAN     = 64'h7FF8_0000_0000_0000;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } fadd_req_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] sum;
  } fadd_rsp_t;

endpackage

FILE: rtl/core/mlfs_if.sv
// Valid/ready channel interfaces for the input, output and configuration ports.
// Depends on mlfs_pkg for the payload widths.
interface mlfs_in_if;
  logic                        valid;
  logic                        ready;
  logic [mlfs_pkg::DATA_W-1:0] value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink   (input valid, input value_bits, output ready);
endinterface

interface mlfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [mlfs_pkg::DATA_W-1:0] sum_bits;
  modport source (output valid, output sum_bits, input ready);
  modport sink   (input valid, input sum_bits, output ready);
endinterface

interface mlfs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mlfs_pkg::CFG_IDX_W-1:0]  index;
  logic [mlfs_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/mlfs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mlfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/mlfs_fp_add.sv
// Four-stage pipelined IEEE-754 binary64 adder, round to nearest even.
// Depends on mlfs_pkg; any NaN result is returned as the canonical quiet NaN.
module mlfs_fp_add (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mlfs_pkg::fadd_req_t req_i,
  output mlfs_pkg::fadd_rsp_t rsp_o
);

  function automatic logic [5:0] lzc56(input logic [55:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd56;
    found = 1'b0;
    for (int i = 55; i >= 0; i--) begin
      if (!found && v[i]) begin
        n     = 6'(55 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Stage 1: unpack, order by magnitude, catch NaN and infinity.
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [63:0] x, y;
  logic [10:0] ex, ey;

  always_comb begin
    a_nan = (req_i.a[62:52] == 11'h7FF) && (req_i.a[51:0] != 52'd0);
    b_nan = (req_i.b[62:52] == 11'h7FF) && (req_i.b[51:0] != 52'd0);
    a_inf = (req_i.a[62:52] == 11'h7FF) && (req_i.a[51:0] == 52'd0);
    b_inf = (req_i.b[62:52] == 11'h7FF) && (req_i.b[51:0] == 52'd0);
    swap  = req_i.b[62:0] > req_i.a[62:0];
    x     = swap ? req_i.b : req_i.a;
    y     = swap ? req_i.a : req_i.b;
    ex    = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    ey    = (y[62:52] == 11'd0) ? 11'd1 : y[62:52];
  end

  logic        s1_valid_q, s1_sign_q, s1_sub_q, s1_spec_q;
  logic [63:0] s1_spec_val_q;
  logic [10:0] s1_e_q, s1_d_q;
  logic [52:0] s1_mx_q, s1_my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sign_q <= x[63];
    s1_sub_q  <= x[63] ^ y[63];
    s1_e_q    <= ex;
    s1_d_q    <= ex - ey;
    s1_mx_q   <= {x[62:52] != 11'd0, x[51:0]};
    s1_my_q   <= {y[62:52] != 11'd0, y[51:0]};
    if (a_nan || b_nan || (a_inf && b_inf && (req_i.a[63] != req_i.b[63]))) begin
      s1_spec_q     <= 1'b1;
      s1_spec_val_q <= mlfs_pkg::FP_QNAN;
    end else if (a_inf || b_inf) begin
      s1_spec_q     <= 1'b1;
      s1_spec_val_q <= x;
    end else begin
      s1_spec_q     <= 1'b0;
      s1_spec_val_q <= x;
    end
  end

  // Stage 2: align the smaller operand with sticky, then add or subtract.
  logic [55:0] mye, sh, yal;
  logic        sticky;
  logic [56:0] sum;

  always_comb begin
    mye = {s1_my_q, 3'b000};
    if (s1_d_q >= 11'd56) begin
      sh     = 56'd0;
      sticky = |s1_my_q;
    end else begin
      sh     = mye >> s1_d_q[5:0];
      sticky = (sh << s1_d_q[5:0]) != mye;
    end
    yal = {sh[55:1], sh[0] | sticky};
    if (s1_sub_q) begin
      sum = {1'b0, s1_mx_q, 3'b000} - {1'b0, yal};
    end else begin
      sum = {1'b0, s1_mx_q, 3'b000} + {1'b0, yal};
    end
  end

  logic        s2_valid_q, s2_sign_q, s2_zsign_q, s2_spec_q;
  logic [63:0] s2_spec_val_q;
  logic [10:0] s2_e_q;
  logic [56:0] s2_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sign_q     <= s1_sign_q;
    s2_zsign_q    <= s1_sub_q ? 1'b0 : s1_sign_q;
    s2_spec_q     <= s1_spec_q;
    s2_spec_val_q <= s1_spec_val_q;
    s2_e_q        <= s1_e_q;
    s2_sum_q      <= sum;
  end

  // Stage 3: leading zero count and the normalize amount, floored at the
  // smallest exponent so that tiny results come out subnormal.
  logic [55:0] m3;
  logic [11:0] e3, emax_sh;
  logic [5:0]  lz, shamt;

  always_comb begin
    lz      = 6'd0;
    shamt   = 6'd0;
    emax_sh = {1'b0, s2_e_q} - 12'd1;
    if (s2_sum_q[56]) begin
      m3 = {s2_sum_q[56:2], s2_sum_q[1] | s2_sum_q[0]};
      e3 = {1'b0, s2_e_q} + 12'd1;
    end else begin
      m3 = s2_sum_q[55:0];
      lz = lzc56(m3);
      if ({6'd0, lz} > emax_sh) begin
        shamt = emax_sh[5:0];
      end else begin
        shamt = lz;
      end
      e3 = {1'b0, s2_e_q} - {6'd0, shamt};
    end
  end

  logic        s3_valid_q, s3_sign_q, s3_zsign_q, s3_zero_q, s3_spec_q;
  logic [63:0] s3_spec_val_q;
  logic [11:0] s3_e_q;
  logic [55:0] s3_m_q;
  logic [5:0]  s3_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_sign_q     <= s2_sign_q;
    s3_zsign_q    <= s2_zsign_q;
    s3_zero_q     <= (s2_sum_q == 57'd0);
    s3_spec_q     <= s2_spec_q;
    s3_spec_val_q <= s2_spec_val_q;
    s3_e_q        <= e3;
    s3_m_q        <= m3;
    s3_sh_q       <= shamt;
  end

  // Stage 4: shift, round to nearest even, pack.
  logic [55:0] mn;
  logic        rnd;
  logic [53:0] mant54;
  logic [52:0] mant;
  logic [11:0] ef;
  logic [63:0] res;

  always_comb begin
    mn     = s3_m_q << s3_sh_q;
    rnd    = mn[2] & (mn[1] | mn[0] | mn[3]);
    mant54 = {1'b0, mn[55:3]} + {53'd0, rnd};
    if (mant54[53]) begin
      mant = mant54[53:1];
      ef   = s3_e_q + 12'd1;
    end else begin
      mant = mant54[52:0];
      ef   = s3_e_q;
    end
    if (s3_spec_q) begin
      res = s3_spec_val_q;
    end else if (s3_zero_q) begin
      res = {s3_zsign_q, 63'd0};
    end else if (ef >= 12'd2047) begin
      res = {s3_sign_q, 11'h7FF, 52'd0};
    end else begin
      res = {s3_sign_q, mant[52] ? ef[10:0] : 11'd0, mant[51:0]};
    end
  end

  logic        s4_valid_q;
  logic [63:0] s4_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_sum_q <= res;
  end

  assign rsp_o.valid = s4_valid_q;
  assign rsp_o.sum   = s4_sum_q;

endmodule

FILE: rtl/core/multi_lane_fp_sum_reduce.sv
// Multi-lane binary64 sum reduction: top level with lane memory and sequencer.
// Depends on mlfs_pkg, the channel interfaces, mlfs_ram and mlfs_fp_add.
//
// Usage: configure the lane count (register 0) and the element count
// (register 1) over cfg_i while the block is idle; every such write also
// drops the run in progress. Then stream element-count binary64 items into
// in_i. Item i of the aligned part is added into lane i mod K; after the
// aligned part the lanes are folded in order 0..K-1 and the tail items are
// added one by one. The sum leaves on out_o after the last item of the run.
//
// Flow: one item is worked on at a time. An aligned item runs a lane memory
// read, then an add through the pipelined adder, then the write back. A tail
// item runs one add into the running total. The first tail item, or the last
// aligned item, also runs the fold: K dependent adds into the running total.
//
// Reset clears the lane valid bits, counters and running total at once, so
// the block accepts items in the first cycle after reset. The result sits
// in an output register; new items are taken while it waits, and only the
// completion of the next run stalls until the receiver takes it.
module multi_lane_fp_sum_reduce (
  input  logic              clk_i,
  input  logic              rst_ni,
  mlfs_in_if.sink           in_i,
  mlfs_out_if.source        out_o,
  mlfs_cfg_if.sink          cfg_i
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LADD  = 4'd1;
  localparam logic [3:0] ST_LWAIT = 4'd2;
  localparam logic [3:0] ST_FRD   = 4'd3;
  localparam logic [3:0] ST_FADD  = 4'd4;
  localparam logic [3:0] ST_FWAIT = 4'd5;
  localparam logic [3:0] ST_TADD  = 4'd6;
  localparam logic [3:0] ST_TWAIT = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [3:0]                          state_q, state_d;
  logic [mlfs_pkg::LANE_CW-1:0]        lanes_cfg_q;
  logic [mlfs_pkg::CNT_W-1:0]          element_count_q;
  logic [mlfs_pkg::LANE_AW-1:0]        ptr_q, ptr_d;
  logic [mlfs_pkg::LANE_CW-1:0]        fold_idx_q, fold_idx_d;
  logic [mlfs_pkg::CNT_W-1:0]          rem_q, rem_d;
  logic [mlfs_pkg::DATA_W-1:0]         total_q, total_d;
  logic [mlfs_pkg::DATA_W-1:0]         value_q;
  logic                                folded_q, folded_d;
  logic                                last_q, tail_q;
  logic [mlfs_pkg::MAX_LANES-1:0]      lane_valid_q, lane_valid_d;
  logic                                out_valid_q, out_valid_d;
  logic [mlfs_pkg::DATA_W-1:0]         out_sum_q;

  // Effective register values: zero lanes act as one, too many are clamped,
  // and an element count of zero acts as one.
  logic [mlfs_pkg::LANE_CW-1:0] k_eff;
  logic [mlfs_pkg::CNT_W-1:0]   n_eff;

  always_comb begin
    if (lanes_cfg_q == '0) begin
      k_eff = mlfs_pkg::LANE_CW'(1);
    end else if (lanes_cfg_q > mlfs_pkg::LANE_CW'(mlfs_pkg::MAX_LANES)) begin
      k_eff = mlfs_pkg::LANE_CW'(mlfs_pkg::MAX_LANES);
    end else begin
      k_eff = lanes_cfg_q;
    end
    n_eff = (element_count_q == '0) ? mlfs_pkg::CNT_W'(1) : element_count_q;
  end

  // An item belongs to the aligned part when its lane group is complete:
  // the items left, counted from the group start, cover all K lanes.
  logic in_acc, aligned, cfg_hit;
  logic [mlfs_pkg::CNT_W:0] group_left;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign group_left  = {1'b0, rem_q} + (mlfs_pkg::CNT_W + 1)'(ptr_q);
  assign aligned     = !folded_q && (group_left >= (mlfs_pkg::CNT_W + 1)'(k_eff));
  assign cfg_i.ready = 1'b1;
  assign cfg_hit     = cfg_i.valid && ((cfg_i.index == mlfs_pkg::REG_LANE_COUNT) ||
                                       (cfg_i.index == mlfs_pkg::REG_ELEMENT_COUNT));

  // Lane memory and adder.
  logic                         ram_we;
  logic [mlfs_pkg::LANE_AW-1:0] ram_raddr;
  logic [mlfs_pkg::DATA_W-1:0]  ram_rdata, lane_val, fold_val;
  mlfs_pkg::fadd_req_t          add_req;
  mlfs_pkg::fadd_rsp_t          add_rsp;

  assign ram_raddr = (state_q == ST_FRD) ? fold_idx_q[mlfs_pkg::LANE_AW-1:0] : ptr_q;
  assign ram_we    = (state_q == ST_LWAIT) && add_rsp.valid;
  // A lane not written in this run reads as +0.0.
  assign lane_val  = lane_valid_q[ptr_q] ? ram_rdata : mlfs_pkg::FP_POS_ZERO;
  assign fold_val  = lane_valid_q[fold_idx_q[mlfs_pkg::LANE_AW-1:0]] ? ram_rdata
                                                                      : mlfs_pkg::FP_POS_ZERO;

  mlfs_ram #(
    .WIDTH (mlfs_pkg::DATA_W),
    .DEPTH (mlfs_pkg::MAX_LANES)
  ) u_lane_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (add_rsp.sum),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    add_req.valid = 1'b0;
    add_req.a     = total_q;
    add_req.b     = value_q;
    case (state_q)
      ST_LADD: begin
        add_req.valid = 1'b1;
        add_req.a     = lane_val;
      end
      ST_FADD: begin
        add_req.valid = 1'b1;
        add_req.b     = fold_val;
      end
      ST_TADD: begin
        add_req.valid = 1'b1;
      end
      default: begin
        add_req.valid = 1'b0;
      end
    endcase
  end

  mlfs_fp_add u_fp_add (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (add_req),
    .rsp_o  (add_rsp)
  );

  // Sequencer.
  logic                          out_free;
  logic [mlfs_pkg::LANE_CW-1:0]  ptr_inc, fold_inc;

  assign out_free = !out_valid_q || out_o.ready;
  assign ptr_inc  = mlfs_pkg::LANE_CW'(ptr_q) + mlfs_pkg::LANE_CW'(1);
  assign fold_inc = fold_idx_q + mlfs_pkg::LANE_CW'(1);

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    fold_idx_d   = fold_idx_q;
    rem_d        = rem_q;
    total_d      = total_q;
    folded_d     = folded_q;
    lane_valid_d = lane_valid_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rem_d = rem_q - mlfs_pkg::CNT_W'(1);
          if (aligned) begin
            state_d = ST_LADD;
          end else if (folded_q) begin
            state_d = ST_TADD;
          end else begin
            state_d    = ST_FRD;
            fold_idx_d = '0;
          end
        end
      end
      ST_LADD: begin
        state_d = ST_LWAIT;
      end
      ST_LWAIT: begin
        if (add_rsp.valid) begin
          lane_valid_d[ptr_q] = 1'b1;
          ptr_d = (ptr_inc >= k_eff) ? '0 : ptr_inc[mlfs_pkg::LANE_AW-1:0];
          if (last_q) begin
            state_d    = ST_FRD;
            fold_idx_d = '0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FRD: begin
        state_d = ST_FADD;
      end
      ST_FADD: begin
        state_d = ST_FWAIT;
      end
      ST_FWAIT: begin
        if (add_rsp.valid) begin
          total_d    = add_rsp.sum;
          fold_idx_d = fold_inc;
          if (fold_inc == k_eff) begin
            folded_d = 1'b1;
            state_d  = tail_q ? ST_TADD : ST_EMIT;
          end else begin
            state_d = ST_FRD;
          end
        end
      end
      ST_TADD: begin
        state_d = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (add_rsp.valid) begin
          total_d = add_rsp.sum;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
          ptr_d        = '0;
          rem_d        = n_eff;
          total_d      = mlfs_pkg::FP_POS_ZERO;
          folded_d     = 1'b0;
          lane_valid_d = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A register write drops the current run.
    if (cfg_hit) begin
      state_d      = ST_IDLE;
      ptr_d        = '0;
      total_d      = mlfs_pkg::FP_POS_ZERO;
      folded_d     = 1'b0;
      lane_valid_d = '0;
      if (cfg_i.index == mlfs_pkg::REG_ELEMENT_COUNT) begin
        rem_d = (cfg_i.data == '0) ? mlfs_pkg::CNT_W'(1) : cfg_i.data;
      end else begin
        rem_d = n_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      lanes_cfg_q     <= mlfs_pkg::LANE_CW'(1);
      element_count_q <= mlfs_pkg::CNT_W'(1);
      ptr_q           <= '0;
      fold_idx_q      <= '0;
      rem_q           <= mlfs_pkg::CNT_W'(1);
      total_q         <= mlfs_pkg::FP_POS_ZERO;
      folded_q        <= 1'b0;
      lane_valid_q    <= '0;
      out_valid_q     <= 1'b0;
      last_q          <= 1'b0;
      tail_q          <= 1'b0;
    end else begin
      state_q      <= state_d;
      ptr_q        <= ptr_d;
      fold_idx_q   <= fold_idx_d;
      rem_q        <= rem_d;
      total_q      <= total_d;
      folded_q     <= folded_d;
      lane_valid_q <= lane_valid_d;
      out_valid_q  <= out_valid_d;
      if (in_acc) begin
        last_q <= (rem_q == mlfs_pkg::CNT_W'(1));
        tail_q <= !aligned;
      end
      if (cfg_i.valid && (cfg_i.index == mlfs_pkg::REG_LANE_COUNT)) begin
        lanes_cfg_q <= cfg_i.data[mlfs_pkg::LANE_CW-1:0];
      end
      if (cfg_i.valid && (cfg_i.index == mlfs_pkg::REG_ELEMENT_COUNT)) begin
        element_count_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      value_q <= in_i.value_bits;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_sum_q <= total_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.sum_bits = out_sum_q;

endmodule

FILE: rtl/core/mlfs_checker.sv
// Port-level checker for the multi-lane sum reduction block, bound to the top.
// Depends on mlfs_pkg for the payload width.
module mlfs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mlfs_pkg::DATA_W-1:0] out_sum
);

  // A result waits until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Items are worked on one at a time: an accepted item closes the input.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // A result only appears after work, never straight out of an open input.
  a_emit_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the input was open");

  // A result sum holds while the receiver stalls.
  a_sum_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_sum))
    else $error("result changed while stalled");

endmodule

bind multi_lane_fp_sum_reduce mlfs_checker u_mlfs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_sum   (out_o.sum_bits)
);
